FILE: design/e2q_pkg.sv
`timescale 1ns / 1ps
package e2q_pkg;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int OUT_BITS_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FRAC = 30;
  localparam logic signed [33:0] INV_GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [ANGLE_BITS_DEF-1:0] roll_angle;
    logic signed [ANGLE_BITS_DEF-1:0] pitch_angle;
    logic signed [ANGLE_BITS_DEF-1:0] yaw_angle;
  } angles_t;

  typedef struct packed {
    logic signed [OUT_BITS_DEF-1:0] quat_x;
    logic signed [OUT_BITS_DEF-1:0] quat_y;
    logic signed [OUT_BITS_DEF-1:0] quat_z;
    logic signed [OUT_BITS_DEF-1:0] quat_w;
  } quat_t;

  function automatic logic signed [33:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
      3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
      6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
      9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
      12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
      15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
      18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
      21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
      24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
      27: t = 32'h00000005; 28: t = 32'h00000003; 29: t = 32'h00000001;
      30: t = 32'h00000001;
      default: t = 32'h00000000;
    endcase
    return $signed({2'b00, t});
  endfunction

  // q4.30 product rounded to nearest
  function automatic logic signed [33:0] qmul(input logic signed [33:0] a,
                                              input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return p[63:30];
  endfunction
endpackage

FILE: design/e2q_cordic.sv
`timescale 1ns / 1ps
module e2q_cordic #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [ANGLE_BITS-1:0] angle,
  output logic signed [33:0]           cos_q,
  output logic signed [33:0]           sin_q
);
  import e2q_pkg::*;
  localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  logic signed [33:0] xs [0:N];
  logic signed [33:0] ys [0:N];
  logic signed [33:0] zs [0:N];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= INV_GAIN;
      ys[0] <= '0;
      if (ANGLE_BITS <= 31) begin
        zs[0] <= 34'(signed'(angle)) <<< (31 - ANGLE_BITS);
      end else begin
        zs[0] <= 34'(signed'(angle)) >>> 1;
      end
      for (int i = 0; i < N; i++) begin
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_turn(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_turn(i);
        end
      end
    end
  end

  assign cos_q = xs[N];
  assign sin_q = ys[N];
endmodule

FILE: design/euler_to_quaternion.sv
`timescale 1ns / 1ps
// euler angles to unit quaternion, rotation order x then y then z
// input channel: in_valid / in_stall with roll, pitch and yaw binary angles
// (half scale equals pi); output channel: out_valid / out_stall with the
// four quaternion components as signed q1.15, saturated to that range.
// a transfer happens on a clock edge with valid high and stall low.
// one item per cycle is accepted unless a valid result at the output is stalled.
// stages: one input register, one cordic stage per iteration, two product
// stages, one sum stage, one output stage.
// the whole pipeline advances together; when the receiver stalls a valid result, every
// stage holds, and in_stall is raised whenever a held result is waiting
// at the output.
// synchronous reset clears all valid bits; payload registers are not reset.
module euler_to_quaternion #(
  parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  e2q_pkg::angles_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output e2q_pkg::quat_t  out_data
);
  import e2q_pkg::*;
  localparam int ANGLE_BITS = ANGLE_BITS_DEF;
  localparam int OUT_BITS = OUT_BITS_DEF;
  localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int DEPTH = N + 5;

  logic [DEPTH-1:0] vld;
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end
  assign out_valid = vld[DEPTH-1];

  logic signed [33:0] cr, sr, cp, sp, cy, sy;
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(N)) u_roll (
    .clk(clk), .en(en), .angle(ANGLE_BITS'(in_data.roll_angle)),
    .cos_q(cr), .sin_q(sr));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(N)) u_pitch (
    .clk(clk), .en(en), .angle(ANGLE_BITS'(in_data.pitch_angle)),
    .cos_q(cp), .sin_q(sp));
  e2q_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(N)) u_yaw (
    .clk(clk), .en(en), .angle(ANGLE_BITS'(in_data.yaw_angle)),
    .cos_q(cy), .sin_q(sy));

  logic signed [33:0] srcp, crsp, crcp, srsp, cy1, sy1;
  logic signed [33:0] t0, t1, t2, t3, t4, t5, t6, t7;
  logic signed [34:0] sx, sy_, sz, sw;

  function automatic logic [OUT_BITS-1:0] to_out(input logic signed [34:0] v);
    logic signed [35:0] r, hi, lo;
    hi = (36'sd1 <<< (OUT_BITS - 1)) - 36'sd1;
    lo = -hi - 36'sd1;
    if (OUT_BITS <= 31) begin
      if (OUT_BITS < 31) begin
        r = (36'(v) + (36'sd1 <<< (30 - OUT_BITS))) >>> (31 - OUT_BITS);
      end else begin
        r = 36'(v);
      end
    end else begin
      r = 36'(v) <<< 1;
    end
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[OUT_BITS-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      srcp <= qmul(sr, cp);
      crsp <= qmul(cr, sp);
      crcp <= qmul(cr, cp);
      srsp <= qmul(sr, sp);
      cy1 <= cy;
      sy1 <= sy;
      t0 <= qmul(srcp, cy1);
      t1 <= qmul(crsp, sy1);
      t2 <= qmul(crsp, cy1);
      t3 <= qmul(srcp, sy1);
      t4 <= qmul(crcp, sy1);
      t5 <= qmul(srsp, cy1);
      t6 <= qmul(crcp, cy1);
      t7 <= qmul(srsp, sy1);
      sx <= 35'(t0) + 35'(t1);
      sy_ <= 35'(t2) - 35'(t3);
      sz <= 35'(t4) + 35'(t5);
      sw <= 35'(t6) - 35'(t7);
      out_data.quat_x <= to_out(sx);
      out_data.quat_y <= to_out(sy_);
      out_data.quat_z <= to_out(sz);
      out_data.quat_w <= to_out(sw);
    end
  end
endmodule

FILE: design/e2q_checker.sv
`timescale 1ns / 1ps
module e2q_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input e2q_pkg::quat_t out_data
);
  import e2q_pkg::*;
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("valid after reset");
  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import e2q_pkg::*;

  localparam int LATENCY = CORDIC_STEPS_DEF + 5;
  localparam int N_RANDOM = 1530;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  angles_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  quat_t out_data;

  quat_t quat_queue[$];
  bit failed = 1'b0;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  typedef struct {
    angles_t ang;
    bit      known;
    quat_t   quat;
  } stim_row_t;

  always #1 clk = ~clk;

  euler_to_quaternion i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic void half_sincos(input logic signed [15:0] ang, output longint c,
                                      output longint s);
    longint x, y, z, dx, dy;
    x = 652032874;
    y = 0;
    z = longint'(ang) <<< 15;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(atan_turn(i));
      end
    end
    c = x;
    s = y;
  endfunction

  function automatic logic signed [15:0] to_q15(longint v);
    longint r;
    r = floor_shr(v + 16384, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic quat_t predict_quat(angles_t a);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_sincos(a.roll_angle, cr, sr);
    half_sincos(a.pitch_angle, cp, sp);
    half_sincos(a.yaw_angle, cy, sy);
    q.quat_x = to_q15(q30_mul(q30_mul(sr, cp), cy) + q30_mul(q30_mul(cr, sp), sy));
    q.quat_y = to_q15(q30_mul(q30_mul(cr, sp), cy) - q30_mul(q30_mul(sr, cp), sy));
    q.quat_z = to_q15(q30_mul(q30_mul(cr, cp), sy) + q30_mul(q30_mul(sr, sp), cy));
    q.quat_w = to_q15(q30_mul(q30_mul(cr, cp), cy) - q30_mul(q30_mul(sr, sp), sy));
    return q;
  endfunction

  function automatic stim_row_t row(int r, int p, int y, bit k = 0,
                                    int qx = 0, int qy = 0, int qz = 0, int qw = 0);
    stim_row_t t;
    t.ang = '{r[15:0], p[15:0], y[15:0]};
    t.known = k;
    t.quat = '{qx[15:0], qy[15:0], qz[15:0], qw[15:0]};
    return t;
  endfunction

  // checker and watchdog
  always @(posedge clk) begin
    quat_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[euler_to_quaternion] ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (quat_queue.size() == 0) begin
          $error("unexpected transfer %h", out_data);
          failed = 1'b1;
        end else begin
          want = quat_queue.pop_front();
          if (out_data.quat_x !== want.quat_x) begin
            $error("quat_x expected %0d actual %0d", want.quat_x, out_data.quat_x);
            failed = 1'b1;
          end
          if (out_data.quat_y !== want.quat_y) begin
            $error("quat_y expected %0d actual %0d", want.quat_y, out_data.quat_y);
            failed = 1'b1;
          end
          if (out_data.quat_z !== want.quat_z) begin
            $error("quat_z expected %0d actual %0d", want.quat_z, out_data.quat_z);
            failed = 1'b1;
          end
          if (out_data.quat_w !== want.quat_w) begin
            $error("quat_w expected %0d actual %0d", want.quat_w, out_data.quat_w);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(negedge clk);
    end
  end

  task automatic send(angles_t a, quat_t want);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_queue.push_back(want);
    @(negedge clk);
  endtask

  initial begin
    stim_row_t dir[$];
    angles_t a;
    int wait_cycles;
    // zero angles give the identity; -pi about one axis gives a unit axis
    dir.push_back(row(0, 0, 0));
    dir.push_back(row(-32768, 0, 0));
    dir.push_back(row(0, -32768, 0));
    dir.push_back(row(0, 0, -32768));
    dir.push_back(row(32767, 0, 0));
    dir.push_back(row(0, 32767, 0));
    dir.push_back(row(0, 0, 32767));
    dir.push_back(row(-32768, -32768, -32768));
    dir.push_back(row(32767, 32767, 32767));
    dir.push_back(row(16384, 0, 0));
    dir.push_back(row(0, 16384, 0));
    dir.push_back(row(0, 0, 16384));
    dir.push_back(row(-16384, 16384, -16384));
    dir.push_back(row(1, -1, 1));
    dir.push_back(row(-1, -1, -1));
    dir.push_back(row(32767, -32768, 32767));
    dir.push_back(row(8192, 8192, 8192));
    dir.push_back(row(21845, -10923, 5461));
    dir.push_back(row(16'h5555, 16'hAAAA, 16'h5555));
    dir.push_back(row(16'hAAAA, 16'h5555, 16'hAAAA));
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir[i]) send(dir[i].ang, dir[i].known ? dir[i].quat : predict_quat(dir[i].ang));
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 200) quiet = 1'b1;
      a.roll_angle = 16'($urandom);
      a.pitch_angle = 16'($urandom);
      a.yaw_angle = 16'($urandom);
      send(a, predict_quat(a));
    end
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (quat_queue.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (LATENCY + 5) @(negedge clk);
    if (!failed && quat_queue.size() == 0) begin
      $display("[euler_to_quaternion] OK");
    end else begin
      $display("[euler_to_quaternion] ERROR");
    end
    $finish;
  end
endmodule
